// ----- sv/aavr_pkg.sv -----
`default_nettype none

package aavr_pkg;

    localparam int DEF_VEC_WIDTH  = 18;
    localparam int DEF_COEF_WIDTH = 16;

    // rotate pipeline depth, issue to result
    localparam int ROT_LAT = 6;

    // front queue and result queue depths, powers of two
    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 8;

endpackage

`default_nettype wire

// ----- sv/axis_angle_vector_rotate.sv -----
// axis_angle_vector_rotate: rotates a signed vector about a unit axis given
// the sine and cosine of the angle (axis, sine, cosine in signed Q2.14).
// input channel: a word with vec, axis, sine and cosine is taken at a rising
//   edge with push high and full low; a 4-word queue sits in front
// result channel: the oldest result is on o_rot_* and o_saturated while
//   empty is low; it is taken at a rising edge with pop high
// path: an accepted word passes the front queue, the 6 rotate pipeline
//   stages and the result queue before empty falls
// throughput: one word per cycle unless stalled; rotate stages fully pipelined
// rounding: stage 1/2 products and row sums rounded half up; outputs clipped
//   to vector width, o_saturated raised when any component was clipped
// stall: words in flight plus waiting results never exceed the 8-word
//   result queue; when pop is held low the rotate stages stop taking words,
//   the front queue fills and full rises
// reset: synchronous, active low; both queues empty, nothing in flight
`default_nettype none

module axis_angle_vector_rotate #(
    parameter int VEC_WIDTH  = aavr_pkg::DEF_VEC_WIDTH,
    parameter int COEF_WIDTH = aavr_pkg::DEF_COEF_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_x,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_y,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_z,
    input  logic signed [COEF_WIDTH-1:0] i_axis_x,
    input  logic signed [COEF_WIDTH-1:0] i_axis_y,
    input  logic signed [COEF_WIDTH-1:0] i_axis_z,
    input  logic signed [COEF_WIDTH-1:0] i_sine_val,
    input  logic signed [COEF_WIDTH-1:0] i_cosine_val,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [VEC_WIDTH-1:0]  o_rot_x,
    output logic signed [VEC_WIDTH-1:0]  o_rot_y,
    output logic signed [VEC_WIDTH-1:0]  o_rot_z,
    output logic                         o_saturated
);
    import aavr_pkg::*;

    localparam int VW    = VEC_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int IN_W  = 3 * VW + 5 * CW;
    localparam int OUT_W = 3 * VW + 1;
    localparam int VB    = 5 * CW;
    localparam int UCW   = $clog2(OUT_DEPTH + 1);

    logic [IN_W-1:0]  in_wdata;
    logic [IN_W-1:0]  in_rdata;
    logic             in_empty;
    logic             issue;
    logic [OUT_W-1:0] out_wdata;
    logic [OUT_W-1:0] out_rdata;
    logic             out_full;
    logic             out_pop;
    logic             dp_valid;
    logic [VW-1:0]    dp_rot_x;
    logic [VW-1:0]    dp_rot_y;
    logic [VW-1:0]    dp_rot_z;
    logic             dp_sat;
    logic [UCW-1:0]   r_used;
    logic [UCW-1:0]   n_used;

    assign in_wdata = {i_vec_x, i_vec_y, i_vec_z, i_axis_x, i_axis_y, i_axis_z,
                       i_sine_val, i_cosine_val};

    aavr_fifo #(
        .WIDTH (IN_W),
        .DEPTH (IN_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_wdata),
        .o_full  (full),
        .i_pop   (issue),
        .o_data  (in_rdata),
        .o_empty (in_empty)
    );

    // result slots reserved from issue until the result word is popped
    assign issue   = !in_empty && (r_used < UCW'(OUT_DEPTH));
    assign out_pop = pop && !empty;
    assign n_used  = r_used + UCW'(issue) - UCW'(out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    aavr_rotate #(
        .VEC_WIDTH  (VEC_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_rotate (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (issue),
        .i_vec_x      (in_rdata[IN_W-1:VB+2*VW]),
        .i_vec_y      (in_rdata[VB+2*VW-1:VB+VW]),
        .i_vec_z      (in_rdata[VB+VW-1:VB]),
        .i_axis_x     (in_rdata[5*CW-1:4*CW]),
        .i_axis_y     (in_rdata[4*CW-1:3*CW]),
        .i_axis_z     (in_rdata[3*CW-1:2*CW]),
        .i_sine_val   (in_rdata[2*CW-1:CW]),
        .i_cosine_val (in_rdata[CW-1:0]),
        .o_valid      (dp_valid),
        .o_rot_x      (dp_rot_x),
        .o_rot_y      (dp_rot_y),
        .o_rot_z      (dp_rot_z),
        .o_saturated  (dp_sat)
    );

    assign out_wdata = {dp_rot_x, dp_rot_y, dp_rot_z, dp_sat};

    aavr_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dp_valid),
        .i_data  (out_wdata),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_rdata),
        .o_empty (empty)
    );

    assign o_rot_x     = out_rdata[3*VW:2*VW+1];
    assign o_rot_y     = out_rdata[2*VW:VW+1];
    assign o_rot_z     = out_rdata[VW:1];
    assign o_saturated = out_rdata[0];

`ifndef SYNTHESIS
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_valid |-> !out_full)
        else $error("result word arrives at full result queue");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UCW'(OUT_DEPTH))
        else $error("result slots overbooked");

    a_pop_booked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_pop |-> r_used != '0)
        else $error("result popped without a booked slot");
`endif

endmodule

`default_nettype wire

// ----- sv/aavr_fifo.sv -----
`default_nettype none

module aavr_fifo #(
    parameter int WIDTH = aavr_pkg::DEF_VEC_WIDTH,
    parameter int DEPTH = aavr_pkg::IN_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign n_wr    = r_wr + PW'(do_push);
    assign n_rd    = r_rd + PW'(do_pop);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PW'(r_wr - r_rd) <= PW'(DEPTH)))
        else $error("queue fill beyond depth");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push && !do_pop |=> !o_empty)
        else $error("pushed word not visible");

    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop && !do_push && (PW'(r_wr - r_rd) == PW'(1)) |=> o_empty)
        else $error("queue not empty after last pop");
`endif

endmodule

`default_nettype wire

// ----- sv/aavr_rotate.sv -----
`default_nettype none

module aavr_rotate #(
    parameter int VEC_WIDTH  = aavr_pkg::DEF_VEC_WIDTH,
    parameter int COEF_WIDTH = aavr_pkg::DEF_COEF_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_x,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_y,
    input  logic signed [VEC_WIDTH-1:0]  i_vec_z,
    input  logic signed [COEF_WIDTH-1:0] i_axis_x,
    input  logic signed [COEF_WIDTH-1:0] i_axis_y,
    input  logic signed [COEF_WIDTH-1:0] i_axis_z,
    input  logic signed [COEF_WIDTH-1:0] i_sine_val,
    input  logic signed [COEF_WIDTH-1:0] i_cosine_val,
    output logic                         o_valid,
    output logic signed [VEC_WIDTH-1:0]  o_rot_x,
    output logic signed [VEC_WIDTH-1:0]  o_rot_y,
    output logic signed [VEC_WIDTH-1:0]  o_rot_z,
    output logic                         o_saturated
);
    import aavr_pkg::*;

    localparam int VW   = VEC_WIDTH;
    localparam int CW   = COEF_WIDTH;
    localparam int FRAC = CW - 2;
    localparam int P1W  = CW + 2;
    localparam int UW   = CW + 1;
    localparam int P2W  = CW + 5;
    localparam int MW   = CW + 6;
    localparam int PP1  = 2 * CW;
    localparam int PP2  = P1W + UW;
    localparam int PP3  = MW + VW;
    localparam int AW   = PP3 + 2;
    localparam int RW   = AW - FRAC;

    localparam int IXX = 0;
    localparam int IYY = 1;
    localparam int IZZ = 2;
    localparam int IXY = 3;
    localparam int IXZ = 4;
    localparam int IYZ = 5;
    localparam int IXS = 6;
    localparam int IYS = 7;
    localparam int IZS = 8;
    localparam int NQ1 = 9;
    localparam int NQ2 = 6;

    localparam logic signed [PP1-1:0] RND1 = {{(PP1-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [PP2-1:0] RND2 = {{(PP2-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [AW-1:0]  RND3 = {{(AW-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [UW-1:0]  ONE  = {3'b001, {FRAC{1'b0}}};
    localparam logic signed [RW-1:0]  VMAX = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [RW-1:0]  VMIN = {{(RW-VW+1){1'b1}}, {(VW-1){1'b0}}};

    logic [ROT_LAT-1:0] r_vld;

    // stage 1: axis products and axis-sine products
    logic signed [CW-1:0]  a_op [NQ1];
    logic signed [CW-1:0]  b_op [NQ1];
    logic signed [PP1-1:0] prod1 [NQ1];
    logic signed [P1W-1:0] n_q1 [NQ1];
    logic signed [P1W-1:0] r_q1 [NQ1];
    logic signed [UW-1:0]  r_uc1;
    logic signed [CW-1:0]  r_c1;
    logic signed [VW-1:0]  r_v1 [3];

    // stage 2: times (1 - cos)
    logic signed [PP2-1:0] prod2 [NQ2];
    logic signed [P2W-1:0] n_q2 [NQ2];
    logic signed [P2W-1:0] r_q2 [NQ2];
    logic signed [P1W-1:0] r_s2 [3];
    logic signed [CW-1:0]  r_c2;
    logic signed [VW-1:0]  r_v2 [3];

    // stage 3: matrix entries, row major
    logic signed [MW-1:0]  n_m3 [9];
    logic signed [MW-1:0]  r_m3 [9];
    logic signed [VW-1:0]  r_v3 [3];

    // stage 4: entry times component
    logic signed [PP3-1:0] n_p4 [9];
    logic signed [PP3-1:0] r_p4 [9];

    // stage 5: row sums, rounded
    logic signed [AW-1:0]  sum5 [3];
    logic signed [RW-1:0]  n_row5 [3];
    logic signed [RW-1:0]  r_row5 [3];

    // stage 6: clipped result
    logic [VW-1:0]         n_rot6 [3];
    logic                  n_sat6;
    logic [VW-1:0]         r_rot6 [3];
    logic                  r_sat6;

    always_comb begin
        a_op[IXX] = i_axis_x;  b_op[IXX] = i_axis_x;
        a_op[IYY] = i_axis_y;  b_op[IYY] = i_axis_y;
        a_op[IZZ] = i_axis_z;  b_op[IZZ] = i_axis_z;
        a_op[IXY] = i_axis_x;  b_op[IXY] = i_axis_y;
        a_op[IXZ] = i_axis_x;  b_op[IXZ] = i_axis_z;
        a_op[IYZ] = i_axis_y;  b_op[IYZ] = i_axis_z;
        a_op[IXS] = i_axis_x;  b_op[IXS] = i_sine_val;
        a_op[IYS] = i_axis_y;  b_op[IYS] = i_sine_val;
        a_op[IZS] = i_axis_z;  b_op[IZS] = i_sine_val;
        for (int k = 0; k < NQ1; k++) begin
            prod1[k] = PP1'(a_op[k]) * PP1'(b_op[k]);
            n_q1[k]  = P1W'((prod1[k] + RND1) >>> FRAC);
        end
    end

    always_comb begin
        for (int k = 0; k < NQ2; k++) begin
            prod2[k] = PP2'(r_q1[k]) * PP2'(r_uc1);
            n_q2[k]  = P2W'((prod2[k] + RND2) >>> FRAC);
        end
    end

    always_comb begin
        n_m3[0] = MW'(r_q2[IXX]) + MW'(r_c2);
        n_m3[1] = MW'(r_q2[IXY]) - MW'(r_s2[2]);
        n_m3[2] = MW'(r_q2[IXZ]) + MW'(r_s2[1]);
        n_m3[3] = MW'(r_q2[IXY]) + MW'(r_s2[2]);
        n_m3[4] = MW'(r_q2[IYY]) + MW'(r_c2);
        n_m3[5] = MW'(r_q2[IYZ]) - MW'(r_s2[0]);
        n_m3[6] = MW'(r_q2[IXZ]) - MW'(r_s2[1]);
        n_m3[7] = MW'(r_q2[IYZ]) + MW'(r_s2[0]);
        n_m3[8] = MW'(r_q2[IZZ]) + MW'(r_c2);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_p4[i*3+j] = PP3'(r_m3[i*3+j]) * PP3'(r_v3[j]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum5[i]   = AW'(r_p4[i*3]) + AW'(r_p4[i*3+1]) + AW'(r_p4[i*3+2]);
            n_row5[i] = RW'((sum5[i] + RND3) >>> FRAC);
        end
    end

    always_comb begin
        n_sat6 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_row5[i] > VMAX) begin
                n_rot6[i] = VMAX[VW-1:0];
                n_sat6    = 1'b1;
            end else if (r_row5[i] < VMIN) begin
                n_rot6[i] = VMIN[VW-1:0];
                n_sat6    = 1'b1;
            end else begin
                n_rot6[i] = r_row5[i][VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q1  <= n_q1;
        r_uc1 <= ONE - UW'(i_cosine_val);
        r_c1  <= i_cosine_val;
        r_v1[0] <= i_vec_x;
        r_v1[1] <= i_vec_y;
        r_v1[2] <= i_vec_z;

        r_q2    <= n_q2;
        r_s2[0] <= r_q1[IXS];
        r_s2[1] <= r_q1[IYS];
        r_s2[2] <= r_q1[IZS];
        r_c2    <= r_c1;
        r_v2    <= r_v1;

        r_m3 <= n_m3;
        r_v3 <= r_v2;

        r_p4 <= n_p4;

        r_row5 <= n_row5;

        r_rot6 <= n_rot6;
        r_sat6 <= n_sat6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROT_LAT-2:0], i_valid};
        end
    end

    assign o_valid     = r_vld[ROT_LAT-1];
    assign o_rot_x     = r_rot6[0];
    assign o_rot_y     = r_rot6[1];
    assign o_rot_z     = r_rot6[2];
    assign o_saturated = r_sat6;

`ifndef SYNTHESIS
    a_lat_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##ROT_LAT o_valid)
        else $error("word lost in rotate pipeline");

    a_lat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> ##ROT_LAT !o_valid)
        else $error("word invented in rotate pipeline");

    a_clip_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ROT_LAT-2] && (r_row5[0] > VMAX || r_row5[0] < VMIN) |=> o_saturated)
        else $error("clipped x without saturation flag");
`endif

endmodule

`default_nettype wire
